// ----- hdl/sha256_byte_stream_hash_core_macros.svh -----
// assertion macros for the sha-256 byte stream hash core checker
// no dependencies; included by the checker file
`ifndef SHA256_BYTE_STREAM_HASH_CORE_MACROS_SVH
`define SHA256_BYTE_STREAM_HASH_CORE_MACROS_SVH

// same-cycle implication, off during reset
`define SHB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define SHB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication that also holds across reset
`define SHB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/shb_pkg.sv -----
// shared types, constants and round functions for the sha-256 core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package shb_pkg;

   typedef logic [15:0][31:0] blk_type;
   typedef logic [7:0][31:0]  hash_type;

   // one block handed from front to back
   typedef struct packed {
      logic    final_blk;
      blk_type blk;
   } job_type;

   // queue status seen by both sides
   typedef struct packed {
      logic nonempty;
      logic full;
   } qstat_type;

   typedef enum logic [2:0] {
      FR_IDLE = 3'b001,
      FR_PAD  = 3'b010,
      FR_LEN  = 3'b100
   } front_state_type;

   typedef enum logic [2:0] {
      BK_IDLE  = 3'b001,
      BK_ROUND = 3'b010,
      BK_DONE  = 3'b100
   } back_state_type;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam int unsigned LEN_POS = 56;

   localparam hash_type IV_HASH = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned amt);
      return (v >> amt) | (v << (32 - amt));
   endfunction

   function automatic logic [31:0] ssig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] ssig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] bsig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] bsig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] r);
      logic [31:0] k;
      case (r)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage
`default_nettype wire

// ----- hdl/shb_front.sv -----
// byte intake: packs bytes into blocks, counts them and builds padding blocks
// depends on shb_pkg
`timescale 1ns / 1ps
`default_nettype none
module shb_front #(
   parameter int COUNT_WIDTH = 61
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire  [7:0]            req_data_byte,
   input  wire                   req_no_byte,
   input  wire                   req_last,
   input  shb_pkg::qstat_type    q_stat,
   output logic                  push,
   output shb_pkg::job_type      push_job
);
   import shb_pkg::*;

   front_state_type        state_ff, state_in;
   logic [31:0]            blk_ff [16];
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [5:0]             pos;
   logic                   acc;
   logic [63:0]            bit_len;
   blk_type                raw_blk, pad_blk, len_blk;
   logic [5:0]             p;

   assign pos     = cnt_ff[5:0];
   assign bit_len = 64'({cnt_ff, 3'b000});
   assign acc     = req_valid && !req_stall;
   assign req_stall = (state_ff != FR_IDLE) || q_stat.full;

   always_comb begin
      for (int i = 0; i < 16; i++) begin
         raw_blk[i] = blk_ff[i];
         len_blk[i] = '0;
         for (int j = 0; j < 4; j++) begin
            p = 6'(i * 4 + j);
            if (p < pos) begin
               pad_blk[i][8*(3-j) +: 8] = blk_ff[i][8*(3-j) +: 8];
            end else if (p == pos) begin
               pad_blk[i][8*(3-j) +: 8] = PAD_BYTE;
            end else begin
               pad_blk[i][8*(3-j) +: 8] = '0;
            end
         end
      end
      // length goes in the tail when it fits
      if (pos < 6'(LEN_POS)) begin
         pad_blk[14] = bit_len[63:32];
         pad_blk[15] = bit_len[31:0];
      end
      len_blk[14] = bit_len[63:32];
      len_blk[15] = bit_len[31:0];
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      push_job = '{final_blk: 1'b0, blk: raw_blk};
      unique case (state_ff)
         FR_IDLE: begin
            if (acc) begin
               if (!req_no_byte) begin
                  cnt_in = cnt_ff + 1'b1;
                  if (pos == 6'd63) begin
                     push = 1'b1;
                     push_job.blk[15][7:0] = req_data_byte;
                  end
               end
               if (req_last) begin
                  state_in = FR_PAD;
               end
            end
         end
         FR_PAD: begin
            if (!q_stat.full) begin
               push = 1'b1;
               push_job.blk = pad_blk;
               if (pos < 6'(LEN_POS)) begin
                  push_job.final_blk = 1'b1;
                  cnt_in   = '0;
                  state_in = FR_IDLE;
               end else begin
                  state_in = FR_LEN;
               end
            end
         end
         FR_LEN: begin
            if (!q_stat.full) begin
               push = 1'b1;
               push_job = '{final_blk: 1'b1, blk: len_blk};
               cnt_in   = '0;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == FR_IDLE && acc && !req_no_byte) begin
         blk_ff[pos[5:2]][{~pos[1:0], 3'b000} +: 8] <= req_data_byte;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/shb_queue.sv -----
// two-entry block queue between intake and compression engine
// depends on shb_pkg
`timescale 1ns / 1ps
`default_nettype none
module shb_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  shb_pkg::job_type   push_job,
   input  wire                pop,
   output shb_pkg::job_type   head_job,
   output shb_pkg::qstat_type q_stat
);
   import shb_pkg::*;

   job_type    ent_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] cnt_ff;

   assign head_job        = ent_ff[rd_ff];
   assign q_stat.nonempty = (cnt_ff != 2'd0);
   assign q_stat.full     = (cnt_ff == 2'd2);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop)  rd_ff <= ~rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) ent_ff[wr_ff] <= push_job;
   end

endmodule
`default_nettype wire

// ----- hdl/shb_back.sv -----
// compression engine: one round per cycle, chaining words and digest beat buffer
// depends on shb_pkg
`timescale 1ns / 1ps
`default_nettype none
module shb_back (
   input  wire                clock,
   input  wire                reset,
   input  shb_pkg::qstat_type q_stat,
   input  shb_pkg::job_type   head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [31:0]        rsp_digest_word,
   output logic               rsp_last_word
);
   import shb_pkg::*;

   back_state_type state_ff;
   logic [31:0]    w_ff [16];
   logic [31:0]    wv_ff [8];
   hash_type       chain_ff;
   hash_type       sum;
   logic [5:0]     rnd_ff;
   logic           final_ff;
   logic [31:0]    ob_ff [8];
   logic [3:0]     ob_cnt_ff;
   logic [31:0]    w_new, t1, t2;
   logic           out_take, fin_take;

   assign w_new = ssig1(w_ff[14]) + w_ff[9] + ssig0(w_ff[1]) + w_ff[0];
   assign t1 = wv_ff[7] + bsig1(wv_ff[4])
             + ((wv_ff[4] & wv_ff[5]) ^ (~wv_ff[4] & wv_ff[6]))
             + round_k(rnd_ff) + w_ff[0];
   assign t2 = bsig0(wv_ff[0])
             + ((wv_ff[0] & wv_ff[1]) ^ (wv_ff[0] & wv_ff[2]) ^ (wv_ff[1] & wv_ff[2]));

   always_comb begin
      for (int i = 0; i < 8; i++) sum[i] = chain_ff[i] + wv_ff[i];
   end

   assign pop      = (state_ff == BK_IDLE) && q_stat.nonempty;
   assign fin_take = (state_ff == BK_DONE) && (!final_ff || ob_cnt_ff == 4'd0);

   assign rsp_valid       = (ob_cnt_ff != 4'd0);
   assign rsp_digest_word = ob_ff[0];
   assign rsp_last_word   = (ob_cnt_ff == 4'd1);
   assign out_take        = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         chain_ff  <= IV_HASH;
         ob_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            BK_IDLE:  if (pop) state_ff <= BK_ROUND;
            BK_ROUND: if (rnd_ff == 6'd63) state_ff <= BK_DONE;
            BK_DONE: begin
               if (fin_take) begin
                  state_ff <= BK_IDLE;
                  chain_ff <= final_ff ? IV_HASH : sum;
               end
            end
            default: state_ff <= BK_IDLE;
         endcase
         if (fin_take && final_ff) begin
            ob_cnt_ff <= 4'd8;
         end else if (out_take) begin
            ob_cnt_ff <= ob_cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= head_job.blk[i];
         for (int i = 0; i < 8; i++)  wv_ff[i] <= chain_ff[i];
         rnd_ff   <= '0;
         final_ff <= head_job.final_blk;
      end else if (state_ff == BK_ROUND) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= w_new;
         wv_ff[7] <= wv_ff[6];
         wv_ff[6] <= wv_ff[5];
         wv_ff[5] <= wv_ff[4];
         wv_ff[4] <= wv_ff[3] + t1;
         wv_ff[3] <= wv_ff[2];
         wv_ff[2] <= wv_ff[1];
         wv_ff[1] <= wv_ff[0];
         wv_ff[0] <= t1 + t2;
         rnd_ff   <= rnd_ff + 6'd1;
      end
      if (fin_take && final_ff) begin
         for (int i = 0; i < 8; i++) ob_ff[i] <= sum[i];
      end else if (out_take) begin
         for (int i = 0; i < 7; i++) ob_ff[i] <= ob_ff[i+1];
      end
   end

endmodule
`default_nettype wire

// ----- hdl/sha256_byte_stream_hash_core.sv -----
// sha-256 over a byte stream: one message byte per input beat, eight digest words out.
// Bytes enter at one per cycle while the two-block queue has room and no padding
// block is being built; the compression engine then handles each 64-byte block in
// steps (load, 64 rounds at one per cycle, chain update), so the long-run rate is
// set by the single shared round unit. A beat with last adds one padding block
// (two when 56 or more bytes sit in the final block) and the digest follows as
// eight beats, h0 first. No-byte beats that are not last are taken and dropped.
// depends on shb_pkg, shb_front, shb_queue, shb_back
`timescale 1ns / 1ps
`default_nettype none
module sha256_byte_stream_hash_core #(
   parameter int COUNT_WIDTH = 61
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [7:0]  req_data_byte,
   input  wire         req_no_byte,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic        rsp_last_word
);
   import shb_pkg::*;

   // queue handshake between intake and engine
   qstat_type q_stat;
   logic      push, pop;
   job_type   push_job, head_job;

   // intake: byte packing, length count, padding blocks
   shb_front #(.COUNT_WIDTH(COUNT_WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_no_byte   (req_no_byte),
      .req_last      (req_last),
      .q_stat        (q_stat),
      .push          (push),
      .push_job      (push_job)
   );

   // decoupling queue so intake can run ahead of the rounds
   shb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_stat   (q_stat)
   );

   // round engine and digest beat buffer
   shb_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .head_job        (head_job),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digest_word (rsp_digest_word),
      .rsp_last_word   (rsp_last_word)
   );

endmodule
`default_nettype wire

// ----- hdl/shb_checker.sv -----
// port-level checks for the sha-256 core, bound to the top level
// depends on sha256_byte_stream_hash_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "sha256_byte_stream_hash_core_macros.svh"
module shb_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_valid,
   input wire        req_stall,
   input wire [7:0]  req_data_byte,
   input wire        req_no_byte,
   input wire        req_last,
   input wire        rsp_valid,
   input wire        rsp_stall,
   input wire [31:0] rsp_digest_word,
   input wire        rsp_last_word
);
   `SHB_ASSERT_NEXT_ALWAYS(a_rst_quiet, reset, !rsp_valid, "result beat right after reset")
   `SHB_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest_word) && $stable(rsp_last_word), "stalled digest beat changed")
   `SHB_ASSERT_NEXT(a_digest_run, rsp_valid && !rsp_stall && !rsp_last_word, rsp_valid, "gap inside a digest")
   `SHB_ASSERT_NEXT(a_pad_busy, req_valid && !req_stall && req_last, req_stall, "beat taken while padding")
endmodule

bind sha256_byte_stream_hash_core shb_checker u_shb_checker (.*);
`default_nettype wire
